### rtl/core/tpkv_pkg.sv
// ----------------------------------------------------------------------------
// tpkv_pkg
// Shared constants, codes and interface types of the two-page key/value store.
// ----------------------------------------------------------------------------
package tpkv_pkg;

    localparam int SLOTS_PER_PAGE = 256;
    localparam int RECS           = SLOTS_PER_PAGE - 1;
    localparam int IDX_W          = $clog2(SLOTS_PER_PAGE);
    localparam int ADDR_W         = IDX_W + 1;
    localparam int MAX_KEYS       = 6;
    localparam int KC_W           = 3;

    localparam logic [IDX_W-1:0] RECS_IDX = IDX_W'(RECS);

    localparam logic [15:0] H_ERASED = 16'hFFFF;
    localparam logic [15:0] H_RECV   = 16'hEEEE;
    localparam logic [15:0] H_VALID  = 16'h0000;
    localparam logic [15:0] KEY_NONE = 16'hFFFF;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOPAGE   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_INIT  = 2'd2;

    localparam logic [1:0] HC_ERASED = 2'd0;
    localparam logic [1:0] HC_RECV   = 2'd1;
    localparam logic [1:0] HC_VALID  = 2'd2;
    localparam logic [1:0] HC_OTHER  = 2'd3;

    localparam logic [2:0] CFG_KEY_COUNT = 3'd0;
    localparam logic [2:0] CFG_KEY_LAST  = 3'd6;

    typedef struct packed {
        logic        load_in;
        logic        scan_start;
        logic        append;
        logic        pg_load;
        logic        pg_val;
        logic        erase_en;
        logic        erase_pg;
        logic        hand_en;
        logic        hand_pg;
        logic [15:0] hand_val;
        logic        format;
        logic        kidx_clr;
        logic        kidx_inc;
        logic        cur_from_table;
        logic        skip_issue;
        logic        skip_capture;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  app_st;
        logic        scan_done;
        logic [1:0]  scan_st;
        logic [15:0] cur_val;
        logic        rd_none;
        logic        rd_pg;
        logic        pg;
        logic [1:0]  h0c;
        logic [1:0]  h1c;
        logic        kidx_end;
        logic        key_is_skip;
    } sts_t;

    function automatic logic [1:0] hdr_class(input logic [15:0] h);
        logic [1:0] c;
        case (h)
            H_ERASED: c = HC_ERASED;
            H_RECV:   c = HC_RECV;
            H_VALID:  c = HC_VALID;
            default:  c = HC_OTHER;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/tpkv_dp.sv
// ----------------------------------------------------------------------------
// tpkv_dp
// Datapath: page headers, fill counts, record memory, key table, scan engine.
// ----------------------------------------------------------------------------
module tpkv_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [15:0]           in_key,
    input  logic [15:0]           in_val,
    input  tpkv_pkg::cmd_t        cmd,
    output tpkv_pkg::sts_t        sts
);
    import tpkv_pkg::*;

    logic [15:0]       hdr_reg [2];
    logic [15:0]       hdr_next [2];
    logic [IDX_W-1:0]  fill_reg [2];
    logic [KC_W-1:0]   kc_reg;
    logic [15:0]       keys_reg [MAX_KEYS];
    logic [15:0]       cur_key_reg, cur_val_reg, skip_reg;
    logic [KC_W-1:0]   kidx_reg;
    logic              pg_reg;

    logic [31:0]       mem [2*SLOTS_PER_PAGE];
    logic [31:0]       rdata_reg;

    logic              scan_act_reg, scan_pend_reg, scan_pg_reg, scan_done_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [1:0]        scan_st_reg;

    logic              rd_none, rd_pg, wr_none, wr_pg;
    logic [1:0]        h0c, h1c, app_st;
    logic [KC_W-1:0]   n_keys;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              app_we;
    logic [31:0]       app_rec;

    assign h0c = hdr_class(hdr_reg[0]);
    assign h1c = hdr_class(hdr_reg[1]);

    // Valid page 0, else 1, is read; the receiving page, if any, is written.
    always_comb
    begin
        rd_none = 1'b0;
        rd_pg   = 1'b0;
        if (h0c == HC_VALID)
            rd_pg = 1'b0;
        else if (h1c == HC_VALID)
            rd_pg = 1'b1;
        else
            rd_none = 1'b1;
        wr_none = 1'b0;
        wr_pg   = 1'b0;
        if (h1c == HC_VALID)
            wr_pg = (h0c == HC_RECV) ? 1'b0 : 1'b1;
        else if (h0c == HC_VALID)
            wr_pg = (h1c == HC_RECV) ? 1'b1 : 1'b0;
        else
            wr_none = 1'b1;
    end

    always_comb
    begin
        if (wr_none)
            app_st = ST_NOPAGE;
        else if (fill_reg[wr_pg] == RECS_IDX)
            app_st = ST_FULL;
        else
            app_st = ST_OK;
    end

    assign app_we  = cmd.append && (app_st == ST_OK);
    assign app_rec = {cur_key_reg, cur_val_reg};
    assign n_keys  = (kc_reg > KC_W'(MAX_KEYS)) ? KC_W'(MAX_KEYS) : kc_reg;

    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            hdr_next[p] = hdr_reg[p];
            if (cmd.erase_en && (cmd.erase_pg == 1'(p)))
                hdr_next[p] = H_ERASED;
            if (cmd.hand_en && (cmd.hand_pg == 1'(p)))
                hdr_next[p] = hdr_next[p] & cmd.hand_val;
        end
        if (cmd.format)
        begin
            hdr_next[0] = H_VALID;
            hdr_next[1] = H_ERASED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 2; p++)
            begin
                hdr_reg[p]  <= H_ERASED;
                fill_reg[p] <= '0;
            end
        end
        else
        begin
            for (int p = 0; p < 2; p++)
            begin
                hdr_reg[p] <= hdr_next[p];
                if (cmd.format || (cmd.erase_en && (cmd.erase_pg == 1'(p))))
                    fill_reg[p] <= '0;
                else if (app_we && (wr_pg == 1'(p)) && (app_rec != '1))
                    fill_reg[p] <= fill_reg[p] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg <= '0;
            for (int i = 0; i < MAX_KEYS; i++)
                keys_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_KEY_COUNT)
                kc_reg <= cfg_data[KC_W-1:0];
            else if (cfg_index <= CFG_KEY_LAST)
                keys_reg[cfg_index - 3'd1] <= cfg_data;
        end
    end

    // Read port: scan engine walks records newest first; the init repair
    // reads slot zero of the receiving page for the key to skip.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {pg_reg, IDX_W'(0)};
        if (cmd.skip_issue)
            rd_en = 1'b1;
        else if (scan_act_reg && !(scan_pend_reg && rdata_reg[31:16] == cur_key_reg)
                 && scan_idx_reg != '0)
        begin
            rd_en   = 1'b1;
            rd_addr = {scan_pg_reg, scan_idx_reg - 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_we)
            mem[{wr_pg, fill_reg[wr_pg]}] <= app_rec;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_act_reg  <= 1'b0;
            scan_pend_reg <= 1'b0;
            scan_done_reg <= 1'b0;
            scan_pg_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            scan_st_reg   <= ST_OK;
        end
        else
        begin
            scan_done_reg <= 1'b0;
            if (cmd.scan_start)
            begin
                scan_pg_reg  <= rd_pg;
                scan_idx_reg <= fill_reg[rd_pg];
                scan_pend_reg <= 1'b0;
                if (rd_none)
                begin
                    scan_done_reg <= 1'b1;
                    scan_st_reg   <= ST_NOPAGE;
                end
                else if (cur_key_reg == KEY_NONE && fill_reg[rd_pg] != RECS_IDX)
                begin
                    // An erased record above the fill level matches this key.
                    scan_done_reg <= 1'b1;
                    scan_st_reg   <= ST_OK;
                end
                else
                    scan_act_reg <= 1'b1;
            end
            else if (scan_act_reg)
            begin
                if (scan_pend_reg && rdata_reg[31:16] == cur_key_reg)
                begin
                    scan_act_reg  <= 1'b0;
                    scan_done_reg <= 1'b1;
                    scan_st_reg   <= ST_OK;
                end
                else if (scan_idx_reg == '0)
                begin
                    scan_act_reg  <= 1'b0;
                    scan_done_reg <= 1'b1;
                    scan_st_reg   <= ST_NOTFOUND;
                end
                else
                begin
                    scan_idx_reg  <= scan_idx_reg - 1'b1;
                    scan_pend_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kidx_reg <= '0;
            pg_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.kidx_clr)
                kidx_reg <= '0;
            else if (cmd.kidx_inc)
                kidx_reg <= kidx_reg + 1'b1;
            if (cmd.pg_load)
                pg_reg <= cmd.pg_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_key_reg <= in_key;
            cur_val_reg <= in_val;
            skip_reg    <= in_key;
        end
        else if (cmd.cur_from_table)
            cur_key_reg <= keys_reg[kidx_reg];
        else if (cmd.scan_start && cur_key_reg == KEY_NONE)
            cur_val_reg <= 16'hFFFF;
        else if (scan_act_reg && scan_pend_reg && rdata_reg[31:16] == cur_key_reg)
            cur_val_reg <= rdata_reg[15:0];
        if (cmd.skip_capture)
            skip_reg <= (fill_reg[pg_reg] == '0) ? KEY_NONE : rdata_reg[31:16];
    end

    always_comb
    begin
        sts.app_st      = app_st;
        sts.scan_done   = scan_done_reg;
        sts.scan_st     = scan_st_reg;
        sts.cur_val     = cur_val_reg;
        sts.rd_none     = rd_none;
        sts.rd_pg       = rd_pg;
        sts.pg          = pg_reg;
        sts.h0c         = h0c;
        sts.h1c         = h1c;
        sts.kidx_end    = (kidx_reg >= n_keys);
        sts.key_is_skip = (kidx_reg < KC_W'(MAX_KEYS)) &&
                          (keys_reg[kidx_reg[KC_W-1:0] < KC_W'(MAX_KEYS) ?
                           kidx_reg : '0] == skip_reg);
    end

endmodule

### rtl/core/tpkv_ctrl.sv
// ----------------------------------------------------------------------------
// tpkv_ctrl
// Controller: sequences read, write, page transfer and init repair.
// ----------------------------------------------------------------------------
module tpkv_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            func,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           read_value,
    output logic [1:0]            status,
    output tpkv_pkg::cmd_t        cmd,
    input  tpkv_pkg::sts_t        sts
);
    import tpkv_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RD_START = 5'd1;
    localparam logic [4:0] S_RD_WAIT  = 5'd2;
    localparam logic [4:0] S_W_APP    = 5'd3;
    localparam logic [4:0] S_W_OLD    = 5'd4;
    localparam logic [4:0] S_W_RECV   = 5'd5;
    localparam logic [4:0] S_W_APP2   = 5'd6;
    localparam logic [4:0] S_CP_CHK   = 5'd7;
    localparam logic [4:0] S_CP_SCAN  = 5'd8;
    localparam logic [4:0] S_CP_WAIT  = 5'd9;
    localparam logic [4:0] S_CP_APP   = 5'd10;
    localparam logic [4:0] S_W_FIN    = 5'd11;
    localparam logic [4:0] S_INIT     = 5'd12;
    localparam logic [4:0] S_I_SKIP0  = 5'd13;
    localparam logic [4:0] S_I_SKIP1  = 5'd14;
    localparam logic [4:0] S_I_FIN    = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0]  state_reg, state_next;
    logic        ret_init_reg, ret_init_next;
    logic [15:0] res_rv_reg, res_rv_next;
    logic [1:0]  res_st_reg, res_st_next;
    logic        out_valid_reg;
    logic [15:0] out_rv_reg;
    logic [1:0]  out_st_reg;
    logic        accept, out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        ret_init_next = ret_init_reg;
        res_rv_next   = res_rv_reg;
        res_st_next   = res_st_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    res_rv_next = '0;
                    res_st_next = ST_OK;
                    case (func)
                        FN_READ:  state_next = S_RD_START;
                        FN_WRITE: state_next = S_W_APP;
                        FN_INIT:  state_next = S_INIT;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_RD_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                if (sts.scan_done)
                begin
                    res_st_next = sts.scan_st;
                    res_rv_next = (sts.scan_st == ST_OK) ? sts.cur_val : '0;
                    state_next  = S_DONE;
                end
            end
            S_W_APP:
            begin
                cmd.append = 1'b1;
                if (sts.app_st == ST_FULL)
                    state_next = S_W_OLD;
                else
                begin
                    res_st_next = sts.app_st;
                    state_next  = S_DONE;
                end
            end
            S_W_OLD:
            begin
                cmd.pg_load = 1'b1;
                cmd.pg_val  = sts.rd_pg;
                if (sts.rd_none)
                begin
                    res_st_next = ST_NOPAGE;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_W_RECV;
            end
            S_W_RECV:
            begin
                cmd.hand_en  = 1'b1;
                cmd.hand_pg  = ~sts.pg;
                cmd.hand_val = H_RECV;
                state_next   = S_W_APP2;
            end
            S_W_APP2:
            begin
                cmd.append = 1'b1;
                if (sts.app_st != ST_OK)
                begin
                    res_st_next = sts.app_st;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.kidx_clr  = 1'b1;
                    ret_init_next = 1'b0;
                    state_next    = S_CP_CHK;
                end
            end
            S_CP_CHK:
            begin
                if (sts.kidx_end)
                    state_next = ret_init_reg ? S_I_FIN : S_W_FIN;
                else if (sts.key_is_skip)
                    cmd.kidx_inc = 1'b1;
                else
                begin
                    cmd.cur_from_table = 1'b1;
                    state_next         = S_CP_SCAN;
                end
            end
            S_CP_SCAN:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_CP_WAIT;
            end
            S_CP_WAIT:
            begin
                if (sts.scan_done)
                begin
                    if (sts.scan_st == ST_OK)
                        state_next = S_CP_APP;
                    else
                    begin
                        cmd.kidx_inc = 1'b1;
                        state_next   = S_CP_CHK;
                    end
                end
            end
            S_CP_APP:
            begin
                cmd.append = 1'b1;
                if (sts.app_st != ST_OK)
                begin
                    res_st_next = sts.app_st;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.kidx_inc = 1'b1;
                    state_next   = S_CP_CHK;
                end
            end
            S_W_FIN:
            begin
                cmd.erase_en = 1'b1;
                cmd.erase_pg = sts.pg;
                cmd.hand_en  = 1'b1;
                cmd.hand_pg  = ~sts.pg;
                cmd.hand_val = H_VALID;
                state_next   = S_DONE;
            end
            S_INIT:
            begin
                state_next = S_DONE;
                case (sts.h0c)
                    HC_ERASED:
                    begin
                        if (sts.h1c == HC_VALID)
                        begin
                            cmd.erase_en = 1'b1;
                            cmd.erase_pg = 1'b0;
                        end
                        else if (sts.h1c == HC_RECV)
                        begin
                            cmd.erase_en = 1'b1;
                            cmd.erase_pg = 1'b0;
                            cmd.hand_en  = 1'b1;
                            cmd.hand_pg  = 1'b1;
                            cmd.hand_val = H_VALID;
                        end
                        else
                            cmd.format = 1'b1;
                    end
                    HC_RECV:
                    begin
                        if (sts.h1c == HC_VALID)
                        begin
                            cmd.pg_load = 1'b1;
                            cmd.pg_val  = 1'b0;
                            state_next  = S_I_SKIP0;
                        end
                        else if (sts.h1c == HC_ERASED)
                        begin
                            cmd.erase_en = 1'b1;
                            cmd.erase_pg = 1'b1;
                            cmd.hand_en  = 1'b1;
                            cmd.hand_pg  = 1'b0;
                            cmd.hand_val = H_VALID;
                        end
                        else
                            cmd.format = 1'b1;
                    end
                    HC_VALID:
                    begin
                        if (sts.h1c == HC_VALID)
                            cmd.format = 1'b1;
                        else if (sts.h1c == HC_ERASED)
                        begin
                            cmd.erase_en = 1'b1;
                            cmd.erase_pg = 1'b1;
                        end
                        else
                        begin
                            cmd.pg_load = 1'b1;
                            cmd.pg_val  = 1'b1;
                            state_next  = S_I_SKIP0;
                        end
                    end
                    default: cmd.format = 1'b1;
                endcase
            end
            S_I_SKIP0:
            begin
                cmd.skip_issue = 1'b1;
                state_next     = S_I_SKIP1;
            end
            S_I_SKIP1:
            begin
                cmd.skip_capture = 1'b1;
                cmd.kidx_clr     = 1'b1;
                ret_init_next    = 1'b1;
                state_next       = S_CP_CHK;
            end
            S_I_FIN:
            begin
                cmd.hand_en  = 1'b1;
                cmd.hand_pg  = sts.pg;
                cmd.hand_val = H_VALID;
                cmd.erase_en = 1'b1;
                cmd.erase_pg = ~sts.pg;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_init_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_init_reg <= ret_init_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_rv_reg <= res_rv_next;
        res_st_reg <= res_st_next;
        if (out_load)
        begin
            out_rv_reg <= res_rv_reg;
            out_st_reg <= res_st_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign read_value = out_rv_reg;
    assign status     = out_st_reg;

endmodule

### rtl/core/two_page_flash_key_value_store_core.sv
// ----------------------------------------------------------------------------
// two_page_flash_key_value_store_core
// Key/value store emulated over two append-only flash pages.
// ----------------------------------------------------------------------------
// One item is taken at a time. A read walks the single read port of the record
// memory from the newest record on the valid page back one record a cycle;
// the valid page holds at most 255 records. A write into a full page, and an
// init that finishes an interrupted transfer, rescan the old page once for
// each configured key other than the one to skip. A finished result waits in
// an output register while the next item is taken. No clearing pass is needed
// after reset.
module two_page_flash_key_value_store_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], key[17:2], write_value[33:18], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_value[15:0], status[17:16], zero pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tpkv_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [15:0] read_value;
    logic [1:0]  status;

    tpkv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .func       (s_tdata[1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .read_value (read_value),
        .status     (status),
        .cmd        (cmd),
        .sts        (sts)
    );

    tpkv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_key    (s_tdata[17:2]),
        .in_val    (s_tdata[33:18]),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign m_tdata = {6'd0, status, read_value};

endmodule

### tb/sv/tb_two_page_flash_key_value_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_page_flash_key_value_store_core
// Drives reads, writes, init items and the unused function code through the
// stream ports, keeps its own model of both flash pages and the key table,
// and compares every result item with the value predicted for it.
// ----------------------------------------------------------------------------
import tpkv_pkg::*;

class kv_scoreboard;
    logic [17:0] pending[$];
    int          errors;

    function void note(logic [15:0] rv, logic [1:0] st);
        pending.push_back({st, rv});
    endfunction

    function void check(logic [23:0] d);
        logic [17:0] e;
        if (pending.size() == 0)
        begin
            $error("result item with nothing expected: %h", d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[15:0] !== e[15:0])
        begin
            $error("read_value expected %h actual %h", e[15:0], d[15:0]);
            errors++;
        end
        if (d[17:16] !== e[17:16])
        begin
            $error("status expected %0d actual %0d", e[17:16], d[17:16]);
            errors++;
        end
        if (d[23:18] !== 6'd0)
        begin
            $error("pad expected 0 actual %h", d[23:18]);
            errors++;
        end
    endfunction
endclass

module tb_two_page_flash_key_value_store_core;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    two_page_flash_key_value_store_core uut (.*);

    kv_scoreboard sb;

    // Predictor state.
    logic [2:0]  m_kc;
    logic [15:0] m_keys[6];
    logic [15:0] m_hdr[2];
    logic [31:0] m_rec[2*RECS];
    bit          quiet;

    function automatic int rd_page();
        if (m_hdr[0] == H_VALID) return 0;
        if (m_hdr[1] == H_VALID) return 1;
        return 2;
    endfunction

    function automatic int wr_page();
        if (m_hdr[1] == H_VALID) return (m_hdr[0] == H_RECV) ? 0 : 1;
        if (m_hdr[0] == H_VALID) return (m_hdr[1] == H_RECV) ? 1 : 0;
        return 2;
    endfunction

    function automatic void wipe(int p);
        m_hdr[p] = H_ERASED;
        for (int i = 0; i < RECS; i++) m_rec[p*RECS+i] = '1;
    endfunction

    function automatic logic [1:0] find_val(logic [15:0] k, output logic [15:0] v);
        int p;
        p = rd_page();
        v = 0;
        if (p == 2) return ST_NOPAGE;
        for (int i = RECS - 1; i >= 0; i--)
            if (m_rec[p*RECS+i][31:16] == k)
            begin
                v = m_rec[p*RECS+i][15:0];
                return ST_OK;
            end
        return ST_NOTFOUND;
    endfunction

    function automatic logic [1:0] add_rec(logic [15:0] k, logic [15:0] v);
        int p;
        p = wr_page();
        if (p == 2) return ST_NOPAGE;
        for (int i = 0; i < RECS; i++)
            if (m_rec[p*RECS+i] == 32'hFFFF_FFFF)
            begin
                m_rec[p*RECS+i] &= {k, v};
                return ST_OK;
            end
        return ST_FULL;
    endfunction

    function automatic logic [1:0] carry_keys(logic [15:0] skip);
        int n;
        logic [15:0] v;
        logic [1:0] st;
        n = (m_kc > MAX_KEYS) ? MAX_KEYS : m_kc;
        for (int i = 0; i < n; i++)
        begin
            if (m_keys[i] == skip) continue;
            if (find_val(m_keys[i], v) != ST_OK) continue;
            st = add_rec(m_keys[i], v);
            if (st != ST_OK) return st;
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] store_pair(logic [15:0] k, logic [15:0] v);
        logic [1:0] st;
        int oldp;
        st = add_rec(k, v);
        if (st != ST_FULL) return st;
        oldp = rd_page();
        if (oldp == 2) return ST_NOPAGE;
        m_hdr[oldp^1] &= H_RECV;
        st = add_rec(k, v);
        if (st != ST_OK) return st;
        st = carry_keys(k);
        if (st != ST_OK) return st;
        wipe(oldp);
        m_hdr[oldp^1] &= H_VALID;
        return ST_OK;
    endfunction

    function automatic void format_both();
        wipe(0);
        m_hdr[0] &= H_VALID;
        wipe(1);
    endfunction

    function automatic logic [1:0] complete_move(int recv);
        logic [1:0] st;
        st = carry_keys(m_rec[recv*RECS][31:16]);
        if (st != ST_OK) return st;
        m_hdr[recv] &= H_VALID;
        wipe(recv ^ 1);
        return ST_OK;
    endfunction

    function automatic logic [1:0] repair();
        logic [15:0] h0, h1;
        h0 = m_hdr[0];
        h1 = m_hdr[1];
        if (h0 == H_ERASED)
        begin
            if (h1 == H_VALID) wipe(0);
            else if (h1 == H_RECV)
            begin
                wipe(0);
                m_hdr[1] &= H_VALID;
            end
            else format_both();
        end
        else if (h0 == H_RECV)
        begin
            if (h1 == H_VALID) return complete_move(0);
            if (h1 == H_ERASED)
            begin
                wipe(1);
                m_hdr[0] &= H_VALID;
            end
            else format_both();
        end
        else if (h0 == H_VALID)
        begin
            if (h1 == H_VALID) format_both();
            else if (h1 == H_ERASED) wipe(1);
            else return complete_move(1);
        end
        else format_both();
        return ST_OK;
    endfunction

    function automatic void predict(logic [1:0] fn, logic [15:0] k, logic [15:0] v);
        logic [15:0] rv;
        logic [1:0]  st;
        rv = 0;
        st = ST_OK;
        if (fn == FN_READ)
        begin
            st = find_val(k, rv);
            if (st != ST_OK) rv = 0;
        end
        else if (fn == FN_WRITE) st = store_pair(k, v);
        else if (fn == FN_INIT) st = repair();
        sb.note(rv, st);
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall bursts until the quiet phase.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check(m_tdata);
            if (gap > 0)
            begin
                gap--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end
            else m_tready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_KEY_COUNT) m_kc = val[2:0];
        else if (idx <= CFG_KEY_LAST) m_keys[idx-1] = val;
    endtask

    // The valid line stays high after an accepted item so that the next item
    // can follow at once; an idle burst or a drain lowers it.
    task automatic send(logic [1:0] fn, logic [15:0] k, logic [15:0] v);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, v, k, fn};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict(fn, k, v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Pick a key, mostly from the table so that transfers carry real data.
    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return m_keys[$urandom_range(0, 5)];
        if (r < 8) return 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    task automatic random_phase(int n, int wr_pct);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2) send(FN_INIT, 16'($urandom), 16'($urandom));
            else if (r < 3) send(2'd3, 16'($urandom), 16'($urandom));
            else if (r < 3 + wr_pct) send(FN_WRITE, pick_key(), 16'($urandom));
            else send(FN_READ, pick_key(), 16'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        quiet = 0;
        m_kc = 0;
        for (int i = 0; i < 6; i++) m_keys[i] = 0;
        wipe(0);
        wipe(1);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No valid page yet: reads and writes report it, then init formats.
        send(FN_READ, 16'h0000, 16'h0000);
        send(FN_WRITE, 16'hFFFE, 16'hFFFF);
        send(2'd3, 16'hFFFF, 16'hFFFF);
        send(FN_INIT, 16'h0, 16'h0);
        send(FN_READ, 16'h1234, 16'h0);
        // An all-ones key matches an erased slot.
        send(FN_READ, 16'hFFFF, 16'h0);
        send(FN_WRITE, 16'h0000, 16'h0000);
        send(FN_WRITE, 16'hFFFE, 16'hFFFF);
        send(FN_WRITE, 16'hFFFF, 16'hA5A5);
        send(FN_READ, 16'hFFFE, 16'h0);
        send(FN_READ, 16'h0000, 16'h0);
        send(FN_INIT, 16'h0, 16'h0);
        drain();

        cfg_write(CFG_KEY_COUNT, 16'd7);
        cfg_write(3'd1, 16'h0000);
        cfg_write(3'd2, 16'hFFFE);
        cfg_write(3'd3, 16'h0003);
        cfg_write(3'd4, 16'h0004);
        cfg_write(3'd5, 16'h5555);
        cfg_write(3'd6, 16'hAAAA);
        cfg_write(3'd7, 16'h1111);
        // Fill the page to force transfers that copy the table keys found on the old page.
        random_phase(330, 75);
        drain();

        cfg_write(CFG_KEY_COUNT, 16'd0);
        random_phase(280, 80);
        send(FN_INIT, 16'h0, 16'h0);
        drain();

        cfg_write(CFG_KEY_COUNT, 16'd3);
        cfg_write(3'd1, 16'h0001);
        cfg_write(3'd2, 16'h0002);
        cfg_write(3'd3, 16'h0001);
        random_phase(150, 60);
        quiet = 1;
        random_phase(150, 60);
        drain();

        if (sb.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
